// ===== sv/ile_pkg.sv =====
package ile_pkg;

  localparam int MODE_W       = 3;
  localparam int POS_W        = 4;
  localparam int VAL_W        = 32;
  localparam int ST_W         = 2;
  localparam int CNT_OUT_W    = 5;
  localparam int DEF_CAPACITY = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_READ   = 3'd0,
    MODE_INSERT = 3'd1,
    MODE_REMOVE = 3'd2,
    MODE_SEARCH = 3'd3,
    MODE_CLEAR  = 3'd4
  } mode_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  // what every cell does on the coming edge
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_t;

  typedef struct packed {
    cell_op_t                 op;
    logic [POS_W-1:0]         pos;
    logic signed [VAL_W-1:0]  value;
  } cell_cmd_t;

endpackage

// ===== sv/ile_if.sv =====
interface ile_in_if;
  import ile_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [MODE_W-1:0]       mode;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] item_value;

  modport source (output valid, mode, position, item_value, input ready);
  modport sink   (input valid, mode, position, item_value, output ready);
endinterface

interface ile_out_if;
  import ile_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] read_value;
  logic [POS_W-1:0]        match_position;
  logic [ST_W-1:0]         status;
  logic [CNT_OUT_W-1:0]    item_count;

  modport source (output valid, read_value, match_position, status, item_count,
                  input ready);
  modport sink   (input valid, read_value, match_position, status, item_count,
                  output ready);
endinterface

// ===== sv/ile_cell.sv =====
module ile_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 5
) (
  input  logic                            clk,
  input  ile_pkg::cell_cmd_t              cmd,
  input  logic [CNT_W-1:0]                count,
  input  logic signed [ile_pkg::VAL_W-1:0] left_val,
  input  logic signed [ile_pkg::VAL_W-1:0] right_val,
  output logic signed [ile_pkg::VAL_W-1:0] entry,
  output logic                            hit
);
  import ile_pkg::*;

  localparam int CMPW = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  logic signed [VAL_W-1:0] entry_r;
  logic signed [VAL_W-1:0] entry_nxt;
  logic [CMPW-1:0]         idx;
  logic [CMPW-1:0]         p;
  logic [CMPW-1:0]         c;

  assign idx = CMPW'(INDEX);
  assign p   = CMPW'(cmd.pos);
  assign c   = CMPW'(count);

  always_comb begin
    entry_nxt = entry_r;
    case (cmd.op)
      CELL_INSERT: begin
        if (idx == p) begin
          entry_nxt = cmd.value;
        end else if (idx > p && idx <= c) begin
          entry_nxt = left_val;
        end
      end
      CELL_REMOVE: begin
        if (idx >= p && (idx + 1'b1) < c) begin
          entry_nxt = right_val;
        end
      end
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  // only occupied cells may report a match
  assign hit   = (idx < c) && (entry_r == cmd.value);

endmodule

// ===== sv/indexed_list_engine_unit.sv =====
// Indexed list engine: an ordered list of up to CAPACITY signed 32-bit values
// held in a row of cells, one entry per cell. Each item carries one request
// (read, insert, remove, search, clear) and yields exactly one result with
// the status and the entry count after the request. All cells shift or
// compare in the same clock, and the result appears in the output register
// on the next edge; with out_ch.ready held high the unit takes one item
// every cycle, and a stalled result only holds off the input for as long
// as it waits. Reset clears the count; entry contents are undefined until
// written, but only occupied positions are ever read. A full list refuses
// inserts with a full status before any position check; read and remove
// reject a position at or past the count.
module indexed_list_engine_unit #(
  parameter int CAPACITY = ile_pkg::DEF_CAPACITY
) (
  input  logic          clk,
  input  logic          rst_n,
  ile_in_if.sink        in_ch,
  ile_out_if.source     out_ch
);
  import ile_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  // control and output registers
  logic [CW-1:0]           count_r, count_nxt;
  logic                    out_valid_r;
  logic signed [VAL_W-1:0] rd_r, rd_nxt;
  logic [POS_W-1:0]        match_r, match_nxt;
  status_t                 status_r, status_nxt;

  logic                    accept;
  cell_cmd_t               cmd;
  logic signed [VAL_W-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]     cell_hit;
  logic [CMPW-1:0]         pos_ext, cnt_ext;
  logic signed [VAL_W-1:0] rd_sel;
  logic                    found;
  logic [POS_W-1:0]        first_idx;
  logic                    full;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign pos_ext = CMPW'(in_ch.position);
  assign cnt_ext = CMPW'(count_r);
  assign full    = (count_r == CW'(CAPACITY));

  // read port: positions are 4 bits wide, so only cells 0 to 15 are reachable
  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (CMPW'(i) == pos_ext) rd_sel = cell_val[i];
    end
  end

  // the lowest-numbered occupied cell that matches wins
  always_comb begin
    found     = 1'b0;
    first_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (cell_hit[i]) begin
        found     = 1'b1;
        first_idx = POS_W'(i);
      end
    end
  end

  // request decode
  always_comb begin
    count_nxt  = count_r;
    rd_nxt     = '0;
    match_nxt  = '0;
    status_nxt = ST_OK;
    cmd.op     = CELL_HOLD;
    cmd.pos    = in_ch.position;
    cmd.value  = in_ch.item_value;
    unique case (mode_t'(in_ch.mode))
      MODE_READ: begin
        if (pos_ext < cnt_ext) rd_nxt = rd_sel;
        else                   status_nxt = ST_RANGE;
      end
      MODE_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else if (pos_ext > cnt_ext) begin
          status_nxt = ST_RANGE;
        end else begin
          cmd.op    = accept ? CELL_INSERT : CELL_HOLD;
          count_nxt = count_r + 1'b1;
        end
      end
      MODE_REMOVE: begin
        if (pos_ext < cnt_ext) begin
          cmd.op    = accept ? CELL_REMOVE : CELL_HOLD;
          count_nxt = count_r - 1'b1;
        end else begin
          status_nxt = ST_RANGE;
        end
      end
      MODE_SEARCH: begin
        if (found) match_nxt  = first_idx;
        else       status_nxt = ST_MISSING;
      end
      MODE_CLEAR: count_nxt = '0;
      default: ;  // unused codes: no change, status ok
    endcase
  end

  // the row of cells; end cells take their own value as the missing neighbour
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [VAL_W-1:0] left_in, right_in;
    if (g == 0) begin : g_first
      assign left_in = cell_val[g];
    end else begin : g_mid_l
      assign left_in = cell_val[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_in = cell_val[g];
    end else begin : g_mid_r
      assign right_in = cell_val[g+1];
    end
    ile_cell #(
      .INDEX (g),
      .CNT_W (CW)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .count     (count_r),
      .left_val  (left_in),
      .right_val (right_in),
      .entry     (cell_val[g]),
      .hit       (cell_hit[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      rd_r     <= rd_nxt;
      match_r  <= match_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.read_value     = rd_r;
  assign out_ch.match_position = match_r;
  assign out_ch.status         = status_r;
  assign out_ch.item_count     = CNT_OUT_W'(count_r);

  // count never runs past the row of cells
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  // a clear empties the list
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.mode == MODE_CLEAR |=> count_r == '0)
    else $error("count not zero after clear");

  // full status only when every cell is occupied
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    accept && status_nxt == ST_FULL |-> full)
    else $error("full status with free cells");

  // every accepted item leaves a result behind
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r && out_ch.item_count == CNT_OUT_W'(count_r))
    else $error("no result after accepted item");

  // a successful insert grows the count by one
  a_insert: assert property (@(posedge clk) disable iff (!rst_n)
    accept && cmd.op == CELL_INSERT |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not grow the list");

endmodule
